// File: src/ackodo_pkg.sv
// ----------------------------------------------------------------------------
// ackodo_pkg
// Shared types, constants and the arctangent table for the Ackermann steering
// and odometry block.
// ----------------------------------------------------------------------------
package ackodo_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int CW  = 36;
    localparam int ZW  = 34;
    localparam int MW  = 64;
    localparam int MBW = 32;
    localparam int DNW = 60;
    localparam int DDW = 35;

    localparam logic signed [CW-1:0] KINV_Q30   = 36'sd652032874;
    localparam logic [MBW-1:0]       PI_Q29     = 32'd1686629713;
    localparam logic [MBW-1:0]       BAM_SCALE  = 32'd11199533;
    localparam logic [DNW-1:0]       STEP_SAT   = 60'd549755813887;
    localparam logic [DDW-1:0]       POS_DIV    = 35'd256000000;

    localparam logic [15:0] WHEEL_BASE_RESET = 16'd3745;
    localparam logic [13:0] MAX_STEER_RESET  = 14'd6431;

    localparam logic CFG_WHEEL_BASE = 1'b0;
    localparam logic CFG_MAX_STEER  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_YV,
        S_VEC,
        S_ROT1,
        S_NUM1,
        S_NUM2,
        S_DEN,
        S_QDIV,
        S_DH,
        S_BAM,
        S_ROT2,
        S_PX1,
        S_PX2,
        S_PXDIV,
        S_PY1,
        S_PY2,
        S_PYDIV,
        S_DONE
    } state_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic [ZW-1:0] r;
        begin
            case (idx)
                5'd0:    r = 34'h03243F6A8;
                5'd1:    r = 34'h01DAC6705;
                5'd2:    r = 34'h00FADBAFC;
                5'd3:    r = 34'h007F56EA6;
                5'd4:    r = 34'h003FEAB76;
                5'd5:    r = 34'h001FFD55B;
                5'd6:    r = 34'h000FFFAAA;
                5'd7:    r = 34'h0007FFF55;
                5'd8:    r = 34'h0003FFFEA;
                5'd9:    r = 34'h0001FFFFD;
                5'd10:   r = 34'h0000FFFFF;
                5'd11:   r = 34'd524288;
                5'd12:   r = 34'd262144;
                5'd13:   r = 34'd131072;
                5'd14:   r = 34'd65536;
                5'd15:   r = 34'd32768;
                5'd16:   r = 34'd16384;
                5'd17:   r = 34'd8192;
                5'd18:   r = 34'd4096;
                5'd19:   r = 34'd2048;
                5'd20:   r = 34'd1024;
                5'd21:   r = 34'd512;
                5'd22:   r = 34'd256;
                5'd23:   r = 34'd128;
                5'd24:   r = 34'd64;
                5'd25:   r = 34'd32;
                5'd26:   r = 34'd16;
                5'd27:   r = 34'd8;
                5'd28:   r = 34'd4;
                5'd29:   r = 34'd2;
                5'd30:   r = 34'd1;
                default: r = 34'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [33:0] d);
        logic signed [33:0] s;
        logic signed [31:0] r;
        begin
            s = {{2{a[31]}}, a} + d;
            if (s > 34'sh07FFFFFFF)
                r = 32'sh7FFFFFFF;
            else if (s < -34'sh080000000)
                r = 32'sh80000000;
            else
                r = s[31:0];
            return r;
        end
    endfunction

endpackage

// File: src/ackodo_cordic.sv
// ----------------------------------------------------------------------------
// ackodo_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotating mode.
// ----------------------------------------------------------------------------
module ackodo_cordic
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  vectoring,
    input  logic signed [ackodo_pkg::CW-1:0]      x_in,
    input  logic signed [ackodo_pkg::CW-1:0]      y_in,
    input  logic signed [ackodo_pkg::ZW-1:0]      z_in,
    output logic signed [ackodo_pkg::CW-1:0]      x_out,
    output logic signed [ackodo_pkg::CW-1:0]      y_out,
    output logic signed [ackodo_pkg::ZW-1:0]      z_out,
    output logic                                  busy,
    output logic                                  done
);

    logic signed [ackodo_pkg::CW-1:0] x_reg, x_next;
    logic signed [ackodo_pkg::CW-1:0] y_reg, y_next;
    logic signed [ackodo_pkg::ZW-1:0] z_reg, z_next;
    logic signed [ackodo_pkg::CW-1:0] xs, ys;
    logic signed [ackodo_pkg::ZW-1:0] t;
    logic                             mode_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [5:0]                       step_reg;
    logic                             rot_pos;
    logic                             last;

    always_comb
    begin
        xs      = x_reg >>> step_reg[4:0];
        ys      = y_reg >>> step_reg[4:0];
        t       = ackodo_pkg::atan_entry(step_reg[4:0]);
        rot_pos = mode_reg ? y_reg[ackodo_pkg::CW-1] : !z_reg[ackodo_pkg::ZW-1];
        last    = (step_reg == 6'(ackodo_pkg::CORDIC_STEPS - 1));
        if (rot_pos)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - t;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= 6'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 6'd1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= vectoring;
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign busy  = busy_reg;
    assign done  = done_reg;

endmodule

// File: src/ackodo_mul.sv
// ----------------------------------------------------------------------------
// ackodo_mul
// Shift-add multiplier, one multiplier bit per cycle, product modulo 2^64.
// ----------------------------------------------------------------------------
module ackodo_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ackodo_pkg::MW-1:0]     a_in,
    input  logic [ackodo_pkg::MBW-1:0]    b_in,
    output logic [ackodo_pkg::MW-1:0]     product,
    output logic                          busy,
    output logic                          done
);

    logic [ackodo_pkg::MW-1:0]  a_reg;
    logic [ackodo_pkg::MBW-1:0] b_reg;
    logic [ackodo_pkg::MW-1:0]  acc_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       b_zero;

    assign b_zero = (b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && b_zero)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
        end
        else if (busy_reg && !b_zero)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[ackodo_pkg::MW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[ackodo_pkg::MBW-1:1]};
        end
    end

    assign product = acc_reg;
    assign busy    = busy_reg;
    assign done    = done_reg;

endmodule

// File: src/ackodo_div.sv
// ----------------------------------------------------------------------------
// ackodo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ackodo_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ackodo_pkg::DNW-1:0]    dividend,
    input  logic [ackodo_pkg::DDW-1:0]    divisor,
    output logic [ackodo_pkg::DNW-1:0]    quotient,
    output logic                          busy,
    output logic                          done
);

    logic [ackodo_pkg::DNW-1:0] num_reg;
    logic [ackodo_pkg::DDW-1:0] den_reg;
    logic [ackodo_pkg::DDW-1:0] rem_reg, rem_next;
    logic [ackodo_pkg::DDW:0]   partial;
    logic                       qbit;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       last;

    always_comb
    begin
        partial = {rem_reg, num_reg[ackodo_pkg::DNW-1]};
        qbit    = (partial >= {1'b0, den_reg});
        if (qbit)
            rem_next = ackodo_pkg::DDW'(partial - {1'b0, den_reg});
        else
            rem_next = partial[ackodo_pkg::DDW-1:0];
        last = (cnt_reg == 6'(ackodo_pkg::DNW - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[ackodo_pkg::DNW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign quotient = num_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

// File: src/ackermann_steer_and_odometry.sv
// ----------------------------------------------------------------------------
// ackermann_steer_and_odometry
// Steering angle from speed and yaw rate, and bicycle-model dead reckoning.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with linear_velocity, yaw_rate and
// elapsed_time. A transfer takes place when in_valid is high and in_stall is
// low. One result follows each input on out_valid/out_stall.
// The block works on one item at a time; in_stall stays high from a transfer
// until the result is moved to the output register. The time an item takes is
// set by the restoring divider, used three times per item, and the shift-add
// multiplier, one bit per cycle, used ten times; the first item after reset
// takes a shorter path that skips the divider.
// A finished result waits in the output register while the receiver stalls,
// and the next item is accepted in the meantime.
// Configuration: cfg_we with cfg_index 0 writes the wheel base, index 1 the
// steering limit; write only while the block is idle.
// Reset clears the pose, the first-item flag and restores the register
// defaults; the first item after reset only arms the integrator.
// ----------------------------------------------------------------------------
module ackermann_steer_and_odometry
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  linear_velocity,
    input  logic signed [15:0]  yaw_rate,
    input  logic [19:0]         elapsed_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [14:0]  steer_angle,
    output logic                steer_valid,
    output logic                odom_updated,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [31:0]         heading,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    ackodo_pkg::state_t state_reg, state_next;

    logic                kick_reg, kick_next;
    logic [15:0]         wheel_base_reg;
    logic [13:0]         max_steer_reg;
    logic signed [31:0]  x_reg, x_next;
    logic signed [31:0]  y_reg, y_next;
    logic [31:0]         yaw_reg, yaw_next;
    logic                seen_reg, seen_next;
    logic                upd_reg, upd_next;

    logic signed [15:0]  v_reg, v_next;
    logic signed [15:0]  w_reg, w_next;
    logic [19:0]         dt_reg, dt_next;
    logic [15:0]         av_reg, av_next;
    logic signed [14:0]  ang_reg, ang_next;
    logic [63:0]         p_reg, p_next;
    logic [34:0]         den_reg, den_next;
    logic signed [40:0]  q_reg, q_next;
    logic                flip_reg, flip_next;
    logic [16:0]         mag_c_reg, mag_c_next;
    logic                neg_c_reg, neg_c_next;
    logic [16:0]         mag_s_reg, mag_s_next;
    logic                neg_s_reg, neg_s_next;

    logic                out_valid_reg, out_valid_next;
    logic signed [14:0]  steer_angle_reg;
    logic                steer_valid_reg;
    logic                odom_updated_reg;
    logic signed [31:0]  pos_x_reg;
    logic signed [31:0]  pos_y_reg;
    logic [31:0]         heading_reg;
    logic                out_load;

    logic                              cor_start, cor_vec, cor_busy, cor_done;
    logic signed [ackodo_pkg::CW-1:0]  cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [ackodo_pkg::ZW-1:0]  cor_z_in, cor_z;
    logic                              mul_start, mul_busy, mul_done;
    logic [ackodo_pkg::MW-1:0]         mul_a, mul_p;
    logic [ackodo_pkg::MBW-1:0]        mul_b;
    logic                              div_start, div_busy, div_done;
    logic [ackodo_pkg::DNW-1:0]        div_n, div_q;
    logic [ackodo_pkg::DDW-1:0]        div_d;

    logic                accept;
    logic [15:0]         wb_eff;
    logic signed [34:0]  zr_sum;
    logic signed [17:0]  zr;
    logic signed [17:0]  lim;
    logic signed [14:0]  ang_clamp;
    logic signed [21:0]  c16w, s16w;
    logic signed [21:0]  c16a, s16a;
    logic signed [35:0]  cf, sf;
    logic [39:0]         qsat;
    logic signed [32:0]  ya, ba;
    logic                bflip;
    logic [63:0]         tdh;
    logic signed [33:0]  pstep;

    ackodo_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cor_start),
        .vectoring (cor_vec),
        .x_in      (cor_x_in),
        .y_in      (cor_y_in),
        .z_in      (cor_z_in),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .z_out     (cor_z),
        .busy      (cor_busy),
        .done      (cor_done)
    );

    ackodo_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .product (mul_p),
        .busy    (mul_busy),
        .done    (mul_done)
    );

    ackodo_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign accept = in_valid && !in_stall;
    assign wb_eff = (wheel_base_reg == 16'd0) ? 16'd1 : wheel_base_reg;

    always_comb
    begin
        zr_sum = {cor_z[ackodo_pkg::ZW-1], cor_z} + 35'sd65536;
        zr     = zr_sum[34:17];
        lim    = {4'b0, max_steer_reg};
        if (zr > lim)
            ang_clamp = lim[14:0];
        else if (zr < -lim)
            ang_clamp = 15'(-lim);
        else
            ang_clamp = zr[14:0];

        cf   = flip_reg ? -cor_x : cor_x;
        sf   = flip_reg ? -cor_y : cor_y;
        c16w = (state_reg == ackodo_pkg::S_ROT2) ? cf[35:14] : cor_x[35:14];
        s16w = (state_reg == ackodo_pkg::S_ROT2) ? sf[35:14] : cor_y[35:14];
        c16a = c16w[21] ? -c16w : c16w;
        s16a = s16w[21] ? -s16w : s16w;

        qsat = (div_q > ackodo_pkg::STEP_SAT) ? ackodo_pkg::STEP_SAT[39:0] : div_q[39:0];

        ya = {yaw_reg[31], yaw_reg};
        if (ya > 33'sh040000000)
        begin
            ba    = ya - 33'sh080000000;
            bflip = 1'b1;
        end
        else if (ya < -33'sh040000000)
        begin
            ba    = ya + 33'sh080000000;
            bflip = 1'b1;
        end
        else
        begin
            ba    = ya;
            bflip = 1'b0;
        end

        tdh   = mul_p + 64'd32768;
        pstep = (v_reg[15] ^ ((state_reg == ackodo_pkg::S_PXDIV) ? neg_c_reg : neg_s_reg))
                ? -{1'b0, div_q[32:0]} : {1'b0, div_q[32:0]};
    end

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        yaw_next     = yaw_reg;
        seen_next    = seen_reg;
        upd_next     = upd_reg;
        v_next       = v_reg;
        w_next       = w_reg;
        dt_next      = dt_reg;
        av_next      = av_reg;
        ang_next     = ang_reg;
        p_next       = p_reg;
        den_next     = den_reg;
        q_next       = q_reg;
        flip_next    = flip_reg;
        mag_c_next   = mag_c_reg;
        neg_c_next   = neg_c_reg;
        mag_s_next   = mag_s_reg;
        neg_s_next   = neg_s_reg;
        out_load     = 1'b0;
        cor_start    = 1'b0;
        cor_vec      = 1'b0;
        cor_x_in     = ackodo_pkg::KINV_Q30;
        cor_y_in     = '0;
        cor_z_in     = '0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_n        = '0;
        div_d        = ackodo_pkg::POS_DIV;

        case (state_reg)
            ackodo_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    v_next   = linear_velocity;
                    w_next   = yaw_rate;
                    dt_next  = elapsed_time;
                    av_next  = linear_velocity[15] ? 16'(-linear_velocity) : linear_velocity;
                    ang_next = '0;
                    if (linear_velocity != 16'sd0 && yaw_rate != 16'sd0)
                    begin
                        state_next = ackodo_pkg::S_YV;
                    end
                    else if (seen_reg)
                    begin
                        upd_next   = 1'b1;
                        state_next = ackodo_pkg::S_ROT1;
                    end
                    else
                    begin
                        seen_next  = 1'b1;
                        upd_next   = 1'b0;
                        state_next = ackodo_pkg::S_DONE;
                    end
                end
            end
            ackodo_pkg::S_YV:
            begin
                if (kick_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = {{48{w_reg[15]}}, w_reg};
                    mul_b     = {16'd0, wheel_base_reg};
                end
                else if (mul_done)
                begin
                    p_next     = mul_p;
                    state_next = ackodo_pkg::S_VEC;
                end
            end
            ackodo_pkg::S_VEC:
            begin
                if (kick_reg)
                begin
                    cor_start = 1'b1;
                    cor_vec   = 1'b1;
                    cor_x_in  = {4'd0, av_reg, 16'd0};
                    cor_y_in  = p_reg[35:0];
                end
                else if (cor_done)
                begin
                    ang_next = ang_clamp;
                    if (seen_reg)
                    begin
                        upd_next   = 1'b1;
                        state_next = ackodo_pkg::S_ROT1;
                    end
                    else
                    begin
                        seen_next  = 1'b1;
                        upd_next   = 1'b0;
                        state_next = ackodo_pkg::S_DONE;
                    end
                end
            end
            ackodo_pkg::S_ROT1:
            begin
                if (kick_reg)
                begin
                    cor_start = 1'b1;
                    cor_z_in  = {{2{ang_reg[14]}}, ang_reg, 17'd0};
                end
                else if (cor_done)
                begin
                    mag_c_next = (c16w <= 22'sd0) ? 17'd1 : c16w[16:0];
                    mag_s_next = s16a[16:0];
                    neg_s_next = s16w[21];
                    state_next = ackodo_pkg::S_NUM1;
                end
            end
            ackodo_pkg::S_NUM1, ackodo_pkg::S_PX1, ackodo_pkg::S_PY1:
            begin
                if (kick_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = {47'd0, (state_reg == ackodo_pkg::S_PX1) ? mag_c_reg : mag_s_reg};
                    mul_b     = {16'd0, av_reg};
                end
                else if (mul_done)
                begin
                    p_next = mul_p;
                    if (state_reg == ackodo_pkg::S_NUM1)
                        state_next = ackodo_pkg::S_NUM2;
                    else if (state_reg == ackodo_pkg::S_PX1)
                        state_next = ackodo_pkg::S_PX2;
                    else
                        state_next = ackodo_pkg::S_PY2;
                end
            end
            ackodo_pkg::S_NUM2, ackodo_pkg::S_PX2, ackodo_pkg::S_PY2:
            begin
                if (kick_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = p_reg;
                    mul_b     = {12'd0, dt_reg};
                end
                else if (mul_done)
                begin
                    p_next = mul_p;
                    if (state_reg == ackodo_pkg::S_NUM2)
                        state_next = ackodo_pkg::S_DEN;
                    else if (state_reg == ackodo_pkg::S_PX2)
                        state_next = ackodo_pkg::S_PXDIV;
                    else
                        state_next = ackodo_pkg::S_PYDIV;
                end
            end
            ackodo_pkg::S_DEN:
            begin
                if (kick_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = {47'd0, mag_c_reg};
                    mul_b     = {16'd0, wb_eff};
                end
                else if (mul_done)
                begin
                    den_next   = mul_p[34:0];
                    state_next = ackodo_pkg::S_QDIV;
                end
            end
            ackodo_pkg::S_QDIV:
            begin
                if (kick_reg)
                begin
                    div_start = 1'b1;
                    div_n     = {p_reg[53:0], 6'd0};
                    div_d     = den_reg;
                end
                else if (div_done)
                begin
                    q_next     = (v_reg[15] ^ neg_s_reg) ? -{1'b0, qsat} : {1'b0, qsat};
                    state_next = ackodo_pkg::S_DH;
                end
            end
            ackodo_pkg::S_DH:
            begin
                if (kick_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = {{23{q_reg[40]}}, q_reg};
                    mul_b     = ackodo_pkg::BAM_SCALE;
                end
                else if (mul_done)
                begin
                    yaw_next   = yaw_reg + tdh[47:16];
                    state_next = ackodo_pkg::S_BAM;
                end
            end
            ackodo_pkg::S_BAM:
            begin
                if (kick_reg)
                begin
                    mul_start = 1'b1;
                    mul_a     = {{31{ba[32]}}, ba};
                    mul_b     = ackodo_pkg::PI_Q29;
                    flip_next = bflip;
                end
                else if (mul_done)
                begin
                    p_next     = mul_p + 64'h20000000;
                    state_next = ackodo_pkg::S_ROT2;
                end
            end
            ackodo_pkg::S_ROT2:
            begin
                if (kick_reg)
                begin
                    cor_start = 1'b1;
                    cor_z_in  = p_reg[63:30];
                end
                else if (cor_done)
                begin
                    mag_c_next = c16a[16:0];
                    neg_c_next = c16w[21];
                    mag_s_next = s16a[16:0];
                    neg_s_next = s16w[21];
                    state_next = ackodo_pkg::S_PX1;
                end
            end
            ackodo_pkg::S_PXDIV, ackodo_pkg::S_PYDIV:
            begin
                if (kick_reg)
                begin
                    div_start = 1'b1;
                    div_n     = p_reg[59:0];
                    div_d     = ackodo_pkg::POS_DIV;
                end
                else if (div_done)
                begin
                    if (state_reg == ackodo_pkg::S_PXDIV)
                    begin
                        x_next     = ackodo_pkg::sat_add32(x_reg, pstep);
                        state_next = ackodo_pkg::S_PY1;
                    end
                    else
                    begin
                        y_next     = ackodo_pkg::sat_add32(y_reg, pstep);
                        state_next = ackodo_pkg::S_DONE;
                    end
                end
            end
            ackodo_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ackodo_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ackodo_pkg::S_IDLE;
            end
        endcase

        kick_next = (state_next != state_reg);

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ackodo_pkg::S_IDLE;
            kick_reg       <= 1'b0;
            wheel_base_reg <= ackodo_pkg::WHEEL_BASE_RESET;
            max_steer_reg  <= ackodo_pkg::MAX_STEER_RESET;
            x_reg          <= '0;
            y_reg          <= '0;
            yaw_reg        <= '0;
            seen_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kick_reg      <= kick_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            yaw_reg       <= yaw_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == ackodo_pkg::CFG_WHEEL_BASE)
                wheel_base_reg <= cfg_data;
            if (cfg_we && cfg_index == ackodo_pkg::CFG_MAX_STEER)
                max_steer_reg <= cfg_data[13:0];
        end
    end

    always_ff @(posedge clk)
    begin
        upd_reg   <= upd_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        dt_reg    <= dt_next;
        av_reg    <= av_next;
        ang_reg   <= ang_next;
        p_reg     <= p_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        flip_reg  <= flip_next;
        mag_c_reg <= mag_c_next;
        neg_c_reg <= neg_c_next;
        mag_s_reg <= mag_s_next;
        neg_s_reg <= neg_s_next;
        if (out_load)
        begin
            steer_angle_reg  <= ang_reg;
            steer_valid_reg  <= (v_reg != 16'sd0);
            odom_updated_reg <= upd_reg;
            pos_x_reg        <= x_reg;
            pos_y_reg        <= y_reg;
            heading_reg      <= yaw_reg;
        end
    end

    assign in_stall     = (state_reg != ackodo_pkg::S_IDLE);
    assign out_valid    = out_valid_reg;
    assign steer_angle  = steer_angle_reg;
    assign steer_valid  = steer_valid_reg;
    assign odom_updated = odom_updated_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign heading      = heading_reg;

`ifndef NO_ASSERTIONS
    a_pose_zero_before_first: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (x_reg == 32'sd0 && y_reg == 32'sd0 && yaw_reg == 32'd0))
        else $error("pose moved before the first item");

    a_mul_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_cordic_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
        cor_start |-> !cor_busy)
        else $error("cordic started while busy");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid && state_reg == ackodo_pkg::S_IDLE))
        else $error("finished item did not reach the output register");
`endif

endmodule
